// ----- hdl/rgb_to_hsv_converter_macros.svh -----
// assertion macros for the rgb to hsv converter
// used by rgb_to_hsv_converter.sv, no other dependencies
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rhc check failed");

// next-cycle implication, disabled while in reset
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rhc check failed");

`endif

// ----- hdl/rhc_pkg.sv -----
// shared types and constants for the rgb to hsv converter
// no dependencies
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int CH_W    = 8;
    localparam int HUE_W   = 11;
    // divider: numerator up to 512*255+255, quotient up to 256
    localparam int NUM_W   = 17;
    localparam int DEN_W   = 9;
    localparam int QUO_W   = 9;
    localparam int CMP_W   = NUM_W + 1;
    localparam int HSUM_W  = 13;

    localparam int SAT_SCALE = 510;   // twice full-scale saturation
    localparam int FRAC_SHIFT = 9;    // twice the 256 steps per sextant

    localparam logic signed [HSUM_W-1:0] HUE_OFF_RED   = 13'sd0;
    localparam logic signed [HSUM_W-1:0] HUE_OFF_GREEN = 13'sd512;
    localparam logic signed [HSUM_W-1:0] HUE_OFF_BLUE  = 13'sd1024;
    localparam logic signed [HSUM_W-1:0] HUE_TURN      = 13'sd1536;

    typedef enum logic [1:0] {
        BR_RED   = 2'd0,
        BR_GREEN = 2'd1,
        BR_BLUE  = 2'd2
    } branch_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  value;
    } hsv_t;

    // first stage: extremes and hue difference
    typedef struct packed {
        logic [CH_W-1:0] maxv;
        logic [CH_W-1:0] spread;
        logic [CH_W-1:0] mag;
        logic            neg;
        branch_t         branch;
    } prep_t;

    // one word in flight through the divider stages
    typedef struct packed {
        logic [NUM_W-1:0] rem_h;
        logic [NUM_W-1:0] rem_s;
        logic [DEN_W-1:0] den_h;
        logic [DEN_W-1:0] den_s;
        logic [QUO_W-1:0] quo_h;
        logic [QUO_W-1:0] quo_s;
        logic             neg;
        logic             grey;
        logic             black;
        branch_t          branch;
        logic [CH_W-1:0]  maxv;
    } div_t;

endpackage

// ----- hdl/rgb_to_hsv_converter.sv -----
// rgb to hsv converter, pipelined, one pixel per clock unless m_ready stalls the output
// depends on rhc_pkg and rgb_to_hsv_converter_macros.svh
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_macros.svh"

// usage
//  s_ channel: one rgb pixel word (red, green, blue) per valid/ready handshake
//  m_ channel: one hsv word (hue, saturation, value) per pixel, in order
//  hue is in sextants with 8 fraction bits (0..1535), saturation 255 = 1.0,
//  value is the largest channel
//  stages from accept to m_valid, in order:
//   (1 extremes stage, 1 operand stage, 9 divider stages, 1 output stage)
//  throughput: one pixel per clock while m_ready does not stall; the two long divisions (hue fraction and
//  saturation) run side by side, one quotient bit per stage
//  stall: each stage holds while the next one is full and stalled, and an
//  empty stage still takes a word, so bubbles are squeezed out and s_ready
//  only drops once every stage holds a word behind a stalled m_ready
//  reset: aresetn (synchronous, active low) empties the pipe; payload
//  registers are not reset
//  grey pixels give hue 0, black pixels give saturation 0 and hue 0
module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  pixel_t s_word,
    output logic   m_valid,
    input  logic   m_ready,
    output hsv_t   m_word
);

    localparam int DIV_STAGES = QUO_W;

    // ---------------------------------------------------------------
    // handshake chain: a stage loads when empty or when it drains
    // ---------------------------------------------------------------
    logic                prep_vld_reg;
    prep_t               prep_reg;
    logic                div_vld_reg [0:DIV_STAGES];
    div_t                div_reg     [0:DIV_STAGES];
    logic                out_vld_reg;
    hsv_t                out_reg;

    logic                out_rdy;
    logic                div_rdy [0:DIV_STAGES];
    logic                prep_rdy;

    assign out_rdy = !out_vld_reg || m_ready;
    assign div_rdy[DIV_STAGES] = !div_vld_reg[DIV_STAGES] || out_rdy;

    genvar gi;
    generate
        for (gi = 0; gi < DIV_STAGES; gi++) begin : g_rdy
            assign div_rdy[gi] = !div_vld_reg[gi] || div_rdy[gi+1];
        end
    endgenerate

    assign prep_rdy = !prep_vld_reg || div_rdy[0];
    assign s_ready  = prep_rdy;

    // ---------------------------------------------------------------
    // stage 1: max, min, branch and signed hue difference
    // ---------------------------------------------------------------
    prep_t           prep_next;
    logic [CH_W-1:0] minv;
    logic [CH_W-1:0] dpos;
    logic [CH_W-1:0] dneg;

    always_comb begin
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        a = '0;
        b = '0;
        prep_next.maxv = s_word.red;
        if (s_word.green > prep_next.maxv) prep_next.maxv = s_word.green;
        if (s_word.blue > prep_next.maxv) prep_next.maxv = s_word.blue;
        minv = s_word.red;
        if (s_word.green < minv) minv = s_word.green;
        if (s_word.blue < minv) minv = s_word.blue;
        prep_next.spread = prep_next.maxv - minv;

        // red wins ties, then green
        if (prep_next.maxv == s_word.red) begin
            prep_next.branch = BR_RED;
        end else if (prep_next.maxv == s_word.green) begin
            prep_next.branch = BR_GREEN;
        end else begin
            prep_next.branch = BR_BLUE;
        end

        unique case (prep_next.branch)
            BR_RED: begin
                a = s_word.green;
                b = s_word.blue;
            end
            BR_GREEN: begin
                a = s_word.blue;
                b = s_word.red;
            end
            BR_BLUE: begin
                a = s_word.red;
                b = s_word.green;
            end
            default: begin
                a = '0;
                b = '0;
            end
        endcase
        dpos = a - b;
        dneg = b - a;
        prep_next.neg = (a < b);
        prep_next.mag = prep_next.neg ? dneg : dpos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (prep_rdy) begin
            prep_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prep_rdy && s_valid) begin
            prep_reg <= prep_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: numerators and denominators for both divisions
    // hue frac  = (512*mag + spread) / (2*spread)   rounds ties away
    // sat       = (510*spread + max) / (2*max)      rounds ties up
    // ---------------------------------------------------------------
    div_t div_first;

    always_comb begin
        div_first.rem_h  = (NUM_W'(prep_reg.mag) << FRAC_SHIFT) + NUM_W'(prep_reg.spread);
        div_first.rem_s  = NUM_W'(prep_reg.spread) * NUM_W'(SAT_SCALE)
                         + NUM_W'(prep_reg.maxv);
        div_first.den_h  = {prep_reg.spread, 1'b0};
        div_first.den_s  = {prep_reg.maxv, 1'b0};
        div_first.quo_h  = '0;
        div_first.quo_s  = '0;
        div_first.neg    = prep_reg.neg;
        div_first.grey   = (prep_reg.spread == '0);
        div_first.black  = (prep_reg.maxv == '0);
        div_first.branch = prep_reg.branch;
        div_first.maxv   = prep_reg.maxv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_vld_reg[0] <= 1'b0;
        end else if (div_rdy[0]) begin
            div_vld_reg[0] <= prep_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_rdy[0] && prep_vld_reg) begin
            div_reg[0] <= div_first;
        end
    end

    // ---------------------------------------------------------------
    // divider stages: restoring, one quotient bit per stage, msb first
    // ---------------------------------------------------------------
    generate
        for (gi = 0; gi < DIV_STAGES; gi++) begin : g_div
            localparam int BITPOS = QUO_W - 1 - gi;
            logic [CMP_W-1:0] trial_h;
            logic [CMP_W-1:0] trial_s;
            logic             take_h;
            logic             take_s;
            div_t             div_next;

            assign trial_h = CMP_W'(div_reg[gi].den_h) << BITPOS;
            assign trial_s = CMP_W'(div_reg[gi].den_s) << BITPOS;
            assign take_h  = ({1'b0, div_reg[gi].rem_h} >= trial_h);
            assign take_s  = ({1'b0, div_reg[gi].rem_s} >= trial_s);

            always_comb begin
                div_next = div_reg[gi];
                if (take_h) begin
                    div_next.rem_h = div_reg[gi].rem_h - trial_h[NUM_W-1:0];
                    div_next.quo_h[BITPOS] = 1'b1;
                end
                if (take_s) begin
                    div_next.rem_s = div_reg[gi].rem_s - trial_s[NUM_W-1:0];
                    div_next.quo_s[BITPOS] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    div_vld_reg[gi+1] <= 1'b0;
                end else if (div_rdy[gi+1]) begin
                    div_vld_reg[gi+1] <= div_vld_reg[gi];
                end
            end

            always_ff @(posedge aclk) begin
                if (div_rdy[gi+1] && div_vld_reg[gi]) begin
                    div_reg[gi+1] <= div_next;
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // output stage: sextant offset, sign, wrap and special cases
    // ---------------------------------------------------------------
    div_t                     div_last;
    logic signed [HSUM_W-1:0] hue_off;
    logic signed [HSUM_W-1:0] hue_frac;
    logic signed [HSUM_W-1:0] hue_sum;
    logic signed [HSUM_W-1:0] hue_wrap;
    hsv_t                     out_next;

    assign div_last = div_reg[DIV_STAGES];

    always_comb begin
        unique case (div_last.branch)
            BR_RED:   hue_off = HUE_OFF_RED;
            BR_GREEN: hue_off = HUE_OFF_GREEN;
            BR_BLUE:  hue_off = HUE_OFF_BLUE;
            default:  hue_off = HUE_OFF_RED;
        endcase
        hue_frac = div_last.neg ? -$signed(HSUM_W'(div_last.quo_h))
                                :  $signed(HSUM_W'(div_last.quo_h));
        hue_sum  = hue_off + hue_frac;
        // only the red branch can go below zero
        hue_wrap = (hue_sum < 0) ? hue_sum + HUE_TURN : hue_sum;

        out_next.value      = div_last.maxv;
        out_next.hue        = div_last.grey ? '0 : hue_wrap[HUE_W-1:0];
        out_next.saturation = div_last.black ? '0 : div_last.quo_s[CH_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_rdy) begin
            out_vld_reg <= div_vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && div_vld_reg[DIV_STAGES]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_word  = out_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `RHC_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, prep_vld_reg)
    `RHC_ASSERT_IMP(a_hue_range, aclk, aresetn, m_valid, m_word.hue < 11'd1536)
    `RHC_ASSERT_IMP(a_black_pixel, aclk, aresetn, m_valid && (m_word.value == '0),
        (m_word.saturation == '0) && (m_word.hue == '0))
    `RHC_ASSERT_IMP(a_full_stall, aclk, aresetn,
        out_vld_reg && !m_ready && div_vld_reg[0] && div_vld_reg[DIV_STAGES] && prep_vld_reg
        && div_vld_reg[1] && div_vld_reg[2] && div_vld_reg[3] && div_vld_reg[4]
        && div_vld_reg[5] && div_vld_reg[6] && div_vld_reg[7] && div_vld_reg[8],
        !s_ready)

endmodule
